// ----- rtl/fepid_pkg.sv -----
// shared types and constants for the filtered-error pid controller
`timescale 1ns / 1ps

package fepid_pkg;

    // field and datapath widths
    localparam int ERR_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int INTEG_W     = 26;
    localparam int DIFF_W      = 17;
    localparam int DRIVE_W     = 32;
    localparam int PROD_P_W    = 32;
    localparam int PROD_I_W    = 42;
    localparam int PROD_D_W    = 33;
    localparam int ACC_W       = 43;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // fixed-point scaling
    localparam int FRAC_SHIFT  = 12;
    localparam int LIMIT_SHIFT = 8;

    // register reset values
    localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 16'sd2048;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 16'sd410;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 16'sd410;
    localparam logic [LIMIT_W-1:0]       LIMIT_RST  = 15'd500;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P = 2'd0,
        CFG_GAIN_I = 2'd1,
        CFG_GAIN_D = 2'd2,
        CFG_LIMIT  = 2'd3
    } cfg_index_t;

    // loop gains handed to the multiply stage
    typedef struct packed {
        logic signed [GAIN_W-1:0] p;
        logic signed [GAIN_W-1:0] i;
        logic signed [GAIN_W-1:0] d;
    } gains_t;

    // terms produced by the state update for one request
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DIFF_W-1:0]  diff;
    } upd_data_t;

endpackage

// ----- rtl/fepid_update.sv -----
// filter and integral state update, one request per cycle while load is high
`timescale 1ns / 1ps

module fepid_update import fepid_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  logic signed [ERR_W-1:0]  error_sample,
    input  logic [LIMIT_W-1:0]       limit,
    output upd_data_t                data_out
);

    logic signed [ERR_W-1:0]   prev_filt_reg, prev_filt_next;
    logic signed [INTEG_W-1:0] integral_reg, integral_next;
    upd_data_t                 data_reg;

    logic signed [ERR_W:0]     pair_sum;
    logic signed [ERR_W-1:0]   filt;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [INTEG_W-1:0] integ_base;
    logic signed [INTEG_W-1:0] integ_sum;
    logic signed [INTEG_W-1:0] bound;
    logic                      out_of_band;

    // floored average, integral add (restarted on a zero error) and band check
    always_comb begin
        pair_sum    = {error_sample[ERR_W-1], error_sample}
                    + {prev_filt_reg[ERR_W-1], prev_filt_reg};
        filt        = pair_sum[ERR_W:1];
        diff        = {filt[ERR_W-1], filt} - {prev_filt_reg[ERR_W-1], prev_filt_reg};
        integ_base  = (error_sample == '0) ? '0 : integral_reg;
        integ_sum   = integ_base + INTEG_W'(filt);
        bound       = $signed({{(INTEG_W-LIMIT_W-LIMIT_SHIFT){1'b0}}, limit,
                               {LIMIT_SHIFT{1'b0}}});
        out_of_band = (integ_sum > bound) || (integ_sum < -bound);
        integral_next  = out_of_band ? '0 : integ_sum;
        prev_filt_next = filt;
    end

    // loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_filt_reg <= '0;
            integral_reg  <= '0;
        end else if (load) begin
            prev_filt_reg <= prev_filt_next;
            integral_reg  <= integral_next;
        end
    end

    // terms for the multiply stage
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg.err   <= error_sample;
            data_reg.integ <= integral_next;
            data_reg.diff  <= diff;
        end
    end

    assign data_out = data_reg;

endmodule

// ----- rtl/fepid_mac.sv -----
// gain multiplies, sum and scaling back to q24.8
`timescale 1ns / 1ps

module fepid_mac import fepid_pkg::*; (
    input  logic                      aclk,
    input  logic                      load_prod,
    input  logic                      load_out,
    input  upd_data_t                 data_in,
    input  gains_t                    gains,
    output logic signed [DRIVE_W-1:0] drive
);

    logic signed [PROD_P_W-1:0] prod_p_reg;
    logic signed [PROD_I_W-1:0] prod_i_reg;
    logic signed [PROD_D_W-1:0] prod_d_reg;
    logic signed [DRIVE_W-1:0]  drive_reg, drive_next;

    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    acc_shift;

    // three products, registered
    always_ff @(posedge aclk) begin
        if (load_prod) begin
            prod_p_reg <= data_in.err * gains.p;
            prod_i_reg <= data_in.integ * gains.i;
            prod_d_reg <= data_in.diff * gains.d;
        end
    end

    // sum and floor shift; |acc| < 2^40 so the shifted value always fits in
    // 32 bits and the truncation to drive loses nothing
    always_comb begin
        acc        = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg);
        acc_shift  = acc >>> FRAC_SHIFT;
        drive_next = DRIVE_W'(acc_shift);
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

// ----- rtl/filtered_error_pid.sv -----
// top level of the filtered-error positional pid controller
`timescale 1ns / 1ps

// Positional PID step on a Q8.8 line-sensor error, with Q4.12 gains.
// s_tdata carries one error sample per request; m_tdata returns one Q24.8
// drive value per request, in the same order.
// The cfg channel writes gain_p (0), gain_i (1), gain_d (2) and
// integral_limit (3); cfg_ready is always high, other indexes cannot occur.
// Write registers only while no request is in flight.
// Without a stall, a request passes the update, product and output registers
// in order, and m_tvalid rises when the output register is loaded.
// Throughput: one request per cycle while m_tready is high; the filter and
// integral feedback is two adds and a band compare closed around the state
// registers; the gain multiplies and sum sit in two further registered stages.
// Reset (aresetn low, synchronous) clears the filter and integral state to
// zero, loads the default gains and limit, and empties the pipeline.
// When m_tready is low, each stage holds once its successor is full; empty
// stages keep filling, so s_tready falls only when all three stages are full.

module filtered_error_pid import fepid_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [ERR_W-1:0]       s_tdata,     // [15:0] error_sample
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [DRIVE_W-1:0]     m_tdata,     // [31:0] drive
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    gains_t                 gains_reg;
    logic [LIMIT_W-1:0]     limit_reg;

    logic                   upd_valid_reg, upd_valid_next;
    logic                   prod_valid_reg, prod_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   adv_upd, adv_prod, adv_out;
    logic                   s_accept;

    upd_data_t              upd_data;
    logic signed [DRIVE_W-1:0] drive;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.p <= GAIN_P_RST;
            gains_reg.i <= GAIN_I_RST;
            gains_reg.d <= GAIN_D_RST;
            limit_reg   <= LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_GAIN_P: gains_reg.p <= cfg_data;
                CFG_GAIN_I: gains_reg.i <= cfg_data;
                CFG_GAIN_D: gains_reg.d <= cfg_data;
                CFG_LIMIT:  limit_reg   <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage advance: a stage moves when its successor is empty or moving
    always_comb begin
        adv_out  = !out_valid_reg || m_tready;
        adv_prod = !prod_valid_reg || adv_out;
        adv_upd  = !upd_valid_reg || adv_prod;
        s_tready = adv_upd;
        s_accept = s_tvalid && adv_upd;

        upd_valid_next  = adv_upd  ? s_tvalid       : upd_valid_reg;
        prod_valid_next = adv_prod ? upd_valid_reg  : prod_valid_reg;
        out_valid_next  = adv_out  ? prod_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upd_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            upd_valid_reg  <= upd_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // filter and integral update
    fepid_update u_update (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (s_accept),
        .error_sample ($signed(s_tdata)),
        .limit        (limit_reg),
        .data_out     (upd_data)
    );

    // gain multiplies and output scaling
    fepid_mac u_mac (
        .aclk      (aclk),
        .load_prod (adv_prod && upd_valid_reg),
        .load_out  (adv_out && prod_valid_reg),
        .data_in   (upd_data),
        .gains     (gains_reg),
        .drive     (drive)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drive;

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    // a request entering an empty pipeline passes the update, product and output registers in order
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !upd_valid_reg && !prod_valid_reg && !out_valid_reg)
        |=> upd_valid_reg ##1 prod_valid_reg ##1 out_valid_reg)
        else $error("request did not reach output in three cycles");

    // a held product stage keeps its request
    a_prod_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_valid_reg && !adv_out) |=> prod_valid_reg)
        else $error("product stage lost a request while stalled");

endmodule

// ----- tb/sv/filtered_error_pid_checker.sv -----
// drive predictor and result checker for the filtered-error pid controller
`timescale 1ns / 1ps

module filtered_error_pid_checker import fepid_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [ERR_W-1:0]      s_tdata,     // [15:0] error_sample
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DRIVE_W-1:0]    m_tdata,     // [31:0] drive
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    // predicted configuration
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [LIMIT_W-1:0]       band_limit;

    // predicted loop state
    logic signed [ERR_W-1:0]  filt_prev;
    int                       integ_sum;

    logic [DRIVE_W-1:0]       predicted_drive[$];
    logic [DRIVE_W-1:0]       want;
    int                       mismatches;

    // one controller step: updates filter and integral, returns the drive
    function automatic logic [DRIVE_W-1:0] pid_step_drive(input logic signed [ERR_W-1:0] err);
        logic signed [ERR_W:0]   pair_sum;
        logic signed [ERR_W-1:0] filt;
        longint                  e_l;
        longint                  f_l;
        longint                  p_l;
        longint                  bound;
        longint                  acc;
        longint                  drv;
        if (err == 0)
            integ_sum = 0;
        // floored average of error and previous filtered error
        pair_sum = (ERR_W+1)'(err) + (ERR_W+1)'(filt_prev);
        filt = ERR_W'(pair_sum >>> 1);
        integ_sum = integ_sum + int'(filt);
        // out of band resets to zero rather than clamping
        bound = longint'(band_limit) * 256;
        if (integ_sum > bound || integ_sum < -bound)
            integ_sum = 0;
        e_l = longint'(err);
        f_l = longint'(filt);
        p_l = longint'(filt_prev);
        acc = longint'(kp) * e_l + longint'(ki) * integ_sum + longint'(kd) * (f_l - p_l);
        drv = acc >>> FRAC_SHIFT;
        if (drv > DRIVE_MAX)
            drv = DRIVE_MAX;
        if (drv < DRIVE_MIN)
            drv = DRIVE_MIN;
        filt_prev = filt;
        return drv[DRIVE_W-1:0];
    endfunction

    initial begin
        errors = 0;
        pending = 0;
        mismatches = 0;
    end

    // watch all three channels at the sampling edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            kp = GAIN_P_RST;
            ki = GAIN_I_RST;
            kd = GAIN_D_RST;
            band_limit = LIMIT_RST;
            filt_prev = '0;
            integ_sum = 0;
            predicted_drive.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_GAIN_P: kp = cfg_data;
                    CFG_GAIN_I: ki = cfg_data;
                    CFG_GAIN_D: kd = cfg_data;
                    CFG_LIMIT:  band_limit = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // compare a returned drive with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (predicted_drive.size() == 0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected drive %0d with no request pending",
                                 $signed(m_tdata));
                end else begin
                    want = predicted_drive.pop_front();
                    if (want !== m_tdata) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("drive differs: expected %0d, got %0d",
                                     $signed(want), $signed(m_tdata));
                    end
                end
            end
            // predict for an accepted request
            if (s_tvalid && s_tready)
                predicted_drive.push_back(pid_step_drive(s_tdata));
        end
        pending = predicted_drive.size();
    end

endmodule

// ----- tb/sv/tb_filtered_error_pid.sv -----
// stimulus and verdict for the filtered-error pid controller
`timescale 1ns / 1ps

module tb_filtered_error_pid;
    import fepid_pkg::*;

    localparam int LATENCY      = 3;
    localparam int HOLD_CYCLES  = 200;
    localparam int BLOCK_ITEMS  = 233;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [ERR_W-1:0]      s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DRIVE_W-1:0]    m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GAIN_P;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int errors;
    int pending;
    int s_idle_pct = 0;
    int m_idle_pct = 0;
    int hold_ask   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int drift      = 1;

    filtered_error_pid dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    filtered_error_pid_checker drive_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // 4 ns clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("filtered_error_pid: mismatch");
        $finish;
    end

    // result side: random back-pressure plus a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES - 1;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(0, 99) >= m_idle_pct);
            end
        end
    end

    // offer one error sample and wait for its request to be taken
    task automatic send_error(input logic [ERR_W-1:0] value);
        @(negedge aclk);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        s_tvalid = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // wait until every drive is back and the pipeline has settled
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // mostly drifting sensor-like errors, with zeros, extremes and noise
    function automatic logic [ERR_W-1:0] rand_error();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 5)
            drift = -drift;
        if (r < 8)
            v = 0;
        else if (r < 20) begin
            case ($urandom_range(0, 3))
                0: v = 32767;
                1: v = -32768;
                2: v = 1;
                default: v = -1;
            endcase
        end else if (r < 70)
            v = drift * int'($urandom_range(0, 3000));
        else
            v = $urandom;
        return v[ERR_W-1:0];
    endfunction

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // default gains: full-scale runs push the integral out of band
        repeat (5) send_error(16'h7FFF);
        repeat (5) send_error(16'h8000);
        send_error(16'h0001);
        send_error(16'hFFFF);
        send_error(16'h0000);
        send_error(16'h0000);
        wait_idle();

        // largest gains and widest band, high limit bit masked off
        write_reg(CFG_GAIN_P, 16'h7FFF);
        write_reg(CFG_GAIN_I, 16'h7FFF);
        write_reg(CFG_GAIN_D, 16'h7FFF);
        write_reg(CFG_LIMIT,  16'hFFFF);
        send_error(16'h7FFF);
        send_error(16'h8000);
        send_error(16'h7FFF);
        wait_idle();

        // most negative gains, zero band keeps only a zero integral
        write_reg(CFG_GAIN_P, 16'h8000);
        write_reg(CFG_GAIN_I, 16'h8000);
        write_reg(CFG_GAIN_D, 16'h8000);
        write_reg(CFG_LIMIT,  16'h0000);
        send_error(16'h8000);
        send_error(16'h7FFF);
        send_error(16'h0000);
        send_error(16'h0005);
        wait_idle();

        // random phases: receiver idle, then sender idle, then neither
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin s_idle_pct = 20; m_idle_pct = 73; end
                1: begin s_idle_pct = 73; m_idle_pct = 20; end
                default: begin s_idle_pct = 0; m_idle_pct = 0; end
            endcase
            for (int blk = 0; blk < 2; blk++) begin
                write_reg(CFG_GAIN_P, CFG_DATA_W'($urandom));
                write_reg(CFG_GAIN_I, CFG_DATA_W'($urandom));
                write_reg(CFG_GAIN_D, CFG_DATA_W'($urandom));
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_LIMIT, CFG_DATA_W'($urandom));
                else
                    write_reg(CFG_LIMIT, {1'($urandom), 15'($urandom_range(0, 400))});
                for (int n = 0; n < BLOCK_ITEMS; n++) begin
                    send_error(rand_error());
                    if (blk == 0 && n == 120)
                        hold_ask++;
                end
                wait_idle();
            end
        end

        repeat (LATENCY + 4) @(negedge aclk);
        if (errors == 0 && pending == 0)
            $display("filtered_error_pid: match");
        else
            $display("filtered_error_pid: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fepid_pkg.sv
rtl/fepid_update.sv
rtl/fepid_mac.sv
rtl/filtered_error_pid.sv
tb/sv/filtered_error_pid_checker.sv
tb/sv/tb_filtered_error_pid.sv
